// ----- sv/psr_pkg.sv -----
package psr_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  localparam int CW = 34;
  localparam int ZW = 36;
  localparam int ANG_SHIFT = 17;
  localparam int PROD_SHIFT = 31;
  localparam int SHEAR_SHIFT = 30;
  localparam int OUT_SHIFT = 29;

  localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
  localparam logic signed [ZW-1:0] PI_Q30 = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1073741824);
  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] sxx;
    logic [31:0] syy;
    logic [31:0] txy;
  } psr_stress_t;

  typedef struct packed {
    logic [31:0] cc;
    logic [31:0] ss;
    logic [31:0] sc;
    logic [31:0] sc2;
    logic [31:0] cms;
    logic [32:0] diff;
  } psr_coef_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0: a = ZW'(843314856);
      1: a = ZW'(497837829);
      2: a = ZW'(263043836);
      3: a = ZW'(133525158);
      4: a = ZW'(67021686);
      5: a = ZW'(33543515);
      6: a = ZW'(16775850);
      7: a = ZW'(8388437);
      8: a = ZW'(4194282);
      9: a = ZW'(2097149);
      10: a = ZW'(1048575);
      11: a = ZW'(524287);
      12: a = ZW'(262143);
      13: a = ZW'(131071);
      14: a = ZW'(65535);
      15: a = ZW'(32767);
      16: a = ZW'(16383);
      17: a = ZW'(8191);
      18: a = ZW'(4095);
      19: a = ZW'(2047);
      20: a = ZW'(1023);
      21: a = ZW'(511);
      22: a = ZW'(255);
      23: a = ZW'(127);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/psr_cordic.sv -----
module psr_cordic #(
  parameter int STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  output logic                in_rdy,
  input  psr_pkg::psr_stress_t in_st,
  input  logic signed [15:0]  in_ang,
  output logic                out_v,
  input  logic                out_rdy,
  output psr_pkg::psr_stress_t out_st,
  output logic signed [31:0]  out_sin,
  output logic signed [31:0]  out_cos
);
  import psr_pkg::*;

  localparam int ITER = (STAGES < CORDIC_STAGES_MAX) ? STAGES : CORDIC_STAGES_MAX;
  localparam int LAST = ITER + 1;

  logic                 en;
  logic [LAST:0]        v_r;
  psr_stress_t          st_r [0:LAST];
  logic signed [CW-1:0] x_r [0:ITER];
  logic signed [CW-1:0] y_r [0:ITER];
  logic signed [ZW-1:0] z_r [0:ITER];
  logic [ITER:0]        flip_r;
  logic signed [15:0]   ang_c;
  logic signed [ZW-1:0] z_ext;
  logic signed [ZW-1:0] z_nxt;
  logic                 flip_nxt;
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  logic signed [31:0]   cos_nxt;
  logic signed [31:0]   sin_nxt;
  logic signed [31:0]   cos_r;
  logic signed [31:0]   sin_r;

  function automatic logic signed [31:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'(ONE_Q30);
    end else if (v < -ONE_Q30) begin
      r = 32'(-ONE_Q30);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  assign en = !v_r[LAST] || out_rdy;
  assign in_rdy = en;
  assign out_v = v_r[LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAST-1:0], in_v};
    end
  end

  // Clamp the angle to +/-ANGLE_LIMIT, then fold it into the half plane the iterations converge on.
  always_comb begin
    if (in_ang > ANGLE_LIMIT) begin
      ang_c = ANGLE_LIMIT;
    end else if (in_ang < -ANGLE_LIMIT) begin
      ang_c = -ANGLE_LIMIT;
    end else begin
      ang_c = in_ang;
    end
    z_ext = {{(ZW-16-ANG_SHIFT){ang_c[15]}}, ang_c, {ANG_SHIFT{1'b0}}};
    if (z_ext > HALF_PI_Q30) begin
      z_nxt = z_ext - PI_Q30;
      flip_nxt = 1'b1;
    end else if (z_ext < -HALF_PI_Q30) begin
      z_nxt = z_ext + PI_Q30;
      flip_nxt = 1'b1;
    end else begin
      z_nxt = z_ext;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      z_r[0] <= z_nxt;
      flip_r[0] <= flip_nxt;
      st_r[0] <= in_st;
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k-1][ZW-1]) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k - 1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k - 1));
          z_r[k] <= z_r[k-1] - atan_q30(k - 1);
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k - 1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k - 1));
          z_r[k] <= z_r[k-1] + atan_q30(k - 1);
        end
        flip_r[k] <= flip_r[k-1];
        st_r[k] <= st_r[k-1];
      end
    end
  end

  always_comb begin
    xf = flip_r[ITER] ? -x_r[ITER] : x_r[ITER];
    yf = flip_r[ITER] ? -y_r[ITER] : y_r[ITER];
    cos_nxt = clamp_unit(xf);
    sin_nxt = clamp_unit(yf);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
      st_r[LAST] <= st_r[ITER];
    end
  end

  assign out_cos = cos_r;
  assign out_sin = sin_r;
  assign out_st = st_r[LAST];

endmodule

// ----- sv/psr_trig.sv -----
module psr_trig (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  output logic                 in_rdy,
  input  psr_pkg::psr_stress_t in_st,
  input  logic signed [31:0]   in_sin,
  input  logic signed [31:0]   in_cos,
  output logic                 out_v,
  input  logic                 out_rdy,
  output psr_pkg::psr_stress_t out_st,
  output psr_pkg::psr_coef_t   out_coef
);
  import psr_pkg::*;

  logic               en;
  logic [1:0]         v_r;
  psr_stress_t        st0_r;
  psr_stress_t        st1_r;
  logic signed [63:0] cc_p_r;
  logic signed [63:0] ss_p_r;
  logic signed [63:0] sc_p_r;
  logic signed [31:0] cc_nxt;
  logic signed [31:0] ss_nxt;
  logic signed [31:0] sc_nxt;
  logic signed [31:0] sc2_nxt;
  psr_coef_t          coef_nxt;
  psr_coef_t          coef_r;

  assign en = !v_r[1] || out_rdy;
  assign in_rdy = en;
  assign out_v = v_r[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cc_p_r <= in_cos * in_cos;
      ss_p_r <= in_sin * in_sin;
      sc_p_r <= in_sin * in_cos;
      st0_r <= in_st;
    end
  end

  // Round half up back to Q.29; the doubled cross term uses one shift less.
  always_comb begin
    cc_nxt = 32'((cc_p_r + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT);
    ss_nxt = 32'((ss_p_r + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT);
    sc_nxt = 32'((sc_p_r + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT);
    sc2_nxt = 32'((sc_p_r + (64'sd1 <<< (SHEAR_SHIFT - 1))) >>> SHEAR_SHIFT);
    coef_nxt.cc = cc_nxt;
    coef_nxt.ss = ss_nxt;
    coef_nxt.sc = sc_nxt;
    coef_nxt.sc2 = sc2_nxt;
    coef_nxt.cms = cc_nxt - ss_nxt;
    coef_nxt.diff = 33'($signed(st0_r.syy)) - 33'($signed(st0_r.sxx));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
      st1_r <= st0_r;
    end
  end

  assign out_coef = coef_r;
  assign out_st = st1_r;

endmodule

// ----- sv/psr_mix.sv -----
module psr_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  output logic                 in_rdy,
  input  psr_pkg::psr_stress_t in_st,
  input  psr_pkg::psr_coef_t   in_coef,
  output logic                 out_v,
  input  logic                 out_rdy,
  output logic signed [31:0]   out_sxx,
  output logic signed [31:0]   out_syy,
  output logic signed [31:0]   out_txy,
  output logic                 out_ovf
);
  import psr_pkg::*;

  logic               en;
  logic [2:0]         v_r;
  logic signed [63:0] xx_c_r;
  logic signed [63:0] yy_s_r;
  logic signed [63:0] t_sc2_r;
  logic signed [63:0] xx_s_r;
  logic signed [63:0] yy_c_r;
  logic signed [63:0] d_sc_r;
  logic signed [63:0] t_cms_r;
  logic signed [63:0] vxx_r;
  logic signed [63:0] vyy_r;
  logic signed [63:0] vt_r;
  logic [32:0]        sxx_nxt;
  logic [32:0]        syy_nxt;
  logic [32:0]        txy_nxt;
  logic signed [31:0] sxx_r;
  logic signed [31:0] syy_r;
  logic signed [31:0] txy_r;
  logic               ovf_r;

  // Returns the saturation flag above the saturated value.
  function automatic logic [32:0] round_sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    logic [32:0] res;
    r = (v + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > SAT_MAX) begin
      res = {1'b1, 32'(SAT_MAX)};
    end else if (r < SAT_MIN) begin
      res = {1'b1, 32'(SAT_MIN)};
    end else begin
      res = {1'b0, 32'(r)};
    end
    return res;
  endfunction

  assign en = !v_r[2] || out_rdy;
  assign in_rdy = en;
  assign out_v = v_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_c_r <= $signed(in_st.sxx) * $signed(in_coef.cc);
      yy_s_r <= $signed(in_st.syy) * $signed(in_coef.ss);
      t_sc2_r <= $signed(in_st.txy) * $signed(in_coef.sc2);
      xx_s_r <= $signed(in_st.sxx) * $signed(in_coef.ss);
      yy_c_r <= $signed(in_st.syy) * $signed(in_coef.cc);
      d_sc_r <= $signed(in_coef.diff) * $signed(in_coef.sc);
      t_cms_r <= $signed(in_st.txy) * $signed(in_coef.cms);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vxx_r <= xx_c_r + yy_s_r + t_sc2_r;
      vyy_r <= xx_s_r + yy_c_r - t_sc2_r;
      vt_r <= d_sc_r + t_cms_r;
    end
  end

  always_comb begin
    sxx_nxt = round_sat(vxx_r);
    syy_nxt = round_sat(vyy_r);
    txy_nxt = round_sat(vt_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxx_r <= sxx_nxt[31:0];
      syy_r <= syy_nxt[31:0];
      txy_r <= txy_nxt[31:0];
      ovf_r <= sxx_nxt[32] || syy_nxt[32] || txy_nxt[32];
    end
  end

  assign out_sxx = sxx_r;
  assign out_syy = syy_r;
  assign out_txy = txy_r;
  assign out_ovf = ovf_r;

endmodule

// ----- sv/plane_stress_rotation.sv -----
// Throughput is one beat per cycle unless out_stall is high; each CORDIC iteration has its own stage.
// A stalled output holds the pipeline in place, with no beat lost or repeated.
// Reset is synchronous and active low, and it clears only the valid bits.
module plane_stress_rotation #(
  parameter int CORDIC_STAGES = psr_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sigma_xx,
  input  logic signed [31:0] in_sigma_yy,
  input  logic signed [31:0] in_tau_xy,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_rot_sigma_xx,
  output logic signed [31:0] out_rot_sigma_yy,
  output logic signed [31:0] out_rot_tau_xy,
  output logic               out_overflow
);
  import psr_pkg::*;

  psr_stress_t        in_st;
  logic               cor_rdy;
  logic               cor_v;
  psr_stress_t        cor_st;
  logic signed [31:0] cor_sin;
  logic signed [31:0] cor_cos;
  logic               trig_rdy;
  logic               trig_v;
  psr_stress_t        trig_st;
  psr_coef_t          trig_coef;
  logic               mix_rdy;

  always_comb begin
    in_st.sxx = in_sigma_xx;
    in_st.syy = in_sigma_yy;
    in_st.txy = in_tau_xy;
  end

  assign in_stall = !cor_rdy;

  psr_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (in_valid),
    .in_rdy (cor_rdy),
    .in_st  (in_st),
    .in_ang (in_angle),
    .out_v  (cor_v),
    .out_rdy(trig_rdy),
    .out_st (cor_st),
    .out_sin(cor_sin),
    .out_cos(cor_cos)
  );

  psr_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (cor_v),
    .in_rdy  (trig_rdy),
    .in_st   (cor_st),
    .in_sin  (cor_sin),
    .in_cos  (cor_cos),
    .out_v   (trig_v),
    .out_rdy (mix_rdy),
    .out_st  (trig_st),
    .out_coef(trig_coef)
  );

  psr_mix u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_v   (trig_v),
    .in_rdy (mix_rdy),
    .in_st  (trig_st),
    .in_coef(trig_coef),
    .out_v  (out_valid),
    .out_rdy(!out_stall),
    .out_sxx(out_rot_sigma_xx),
    .out_syy(out_rot_sigma_yy),
    .out_txy(out_rot_tau_xy),
    .out_ovf(out_overflow)
  );

endmodule

// ----- tb/tb_plane_stress_rotation.sv -----
`timescale 1ns / 100ps

module tb_plane_stress_rotation;

  localparam int STAGE_CNT = psr_pkg::CORDIC_STAGES_DEF;
  localparam int ATAN_LEN = 24;
  localparam longint ANGLE_MAX = 25736;
  localparam longint ANGLE_SCALE = 131072;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam int TRIG_SHIFT = 31;
  localparam int SHEAR_SHIFT = 30;
  localparam int STRESS_SHIFT = 29;
  localparam longint ATAN_Q30 [ATAN_LEN] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767,
    16383, 8191, 4095, 2047,
    1023, 511, 255, 127
  };

  localparam logic signed [31:0] STRESS_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] STRESS_MIN = 32'sh80000000;
  localparam int RANDOM_BEATS = 1030;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = STAGE_CNT + 7 + 20;

  typedef struct {
    logic signed [31:0] sxx;
    logic signed [31:0] syy;
    logic signed [31:0] txy;
    logic               ovf;
  } rot_stress_t;

  class rotation_scoreboard;
    rot_stress_t expected_rot[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    static function logic signed [31:0] saturate(longint v, inout logic ovf);
      if (v > SAT_HI) begin
        ovf = 1'b1;
        return STRESS_MAX;
      end
      if (v < SAT_LO) begin
        ovf = 1'b1;
        return STRESS_MIN;
      end
      return 32'(v);
    endfunction

    function rot_stress_t rotate_stress(logic signed [31:0] sxx, logic signed [31:0] syy,
                                        logic signed [31:0] txy, logic signed [15:0] ang);
      longint z, x, y, dx, dy, s, c, cc, ss, sc, sc2, vxx, vyy, vt;
      logic flip;
      logic ovf;
      rot_stress_t r;
      z = longint'(ang);
      if (z > ANGLE_MAX) z = ANGLE_MAX;
      else if (z < -ANGLE_MAX) z = -ANGLE_MAX;
      z = z * ANGLE_SCALE;
      flip = 1'b0;
      x = GAIN_Q30;
      y = 0;
      if (z > HALF_PI_Q30) begin
        z = z - PI_Q30;
        flip = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        z = z + PI_Q30;
        flip = 1'b1;
      end
      for (int i = 0; i < STAGE_CNT && i < ATAN_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Q30[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Q30[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = (x > ONE_Q30) ? ONE_Q30 : ((x < -ONE_Q30) ? -ONE_Q30 : x);
      s = (y > ONE_Q30) ? ONE_Q30 : ((y < -ONE_Q30) ? -ONE_Q30 : y);
      cc = round_shift(c * c, TRIG_SHIFT);
      ss = round_shift(s * s, TRIG_SHIFT);
      sc = round_shift(s * c, TRIG_SHIFT);
      sc2 = round_shift(s * c, SHEAR_SHIFT);
      vxx = round_shift(longint'(sxx) * cc + longint'(syy) * ss + longint'(txy) * sc2,
                        STRESS_SHIFT);
      vyy = round_shift(longint'(sxx) * ss + longint'(syy) * cc - longint'(txy) * sc2,
                        STRESS_SHIFT);
      vt = round_shift((longint'(syy) - longint'(sxx)) * sc + longint'(txy) * (cc - ss),
                       STRESS_SHIFT);
      ovf = 1'b0;
      r.sxx = saturate(vxx, ovf);
      r.syy = saturate(vyy, ovf);
      r.txy = saturate(vt, ovf);
      r.ovf = ovf;
      return r;
    endfunction

    function void note_input(logic signed [31:0] sxx, logic signed [31:0] syy,
                             logic signed [31:0] txy, logic signed [15:0] ang);
      expected_rot.push_back(rotate_stress(sxx, syy, txy, ang));
    endfunction

    function void check_result(logic signed [31:0] sxx, logic signed [31:0] syy,
                               logic signed [31:0] txy, logic ovf);
      rot_stress_t e;
      if (expected_rot.size() == 0) begin
        $error("Result beat arrived with no expected result pending.");
        errors++;
        return;
      end
      e = expected_rot.pop_front();
      if (sxx !== e.sxx) begin
        $error("rot_sigma_xx: expected %0d, actual %0d", e.sxx, sxx);
        errors++;
      end
      if (syy !== e.syy) begin
        $error("rot_sigma_yy: expected %0d, actual %0d", e.syy, syy);
        errors++;
      end
      if (txy !== e.txy) begin
        $error("rot_tau_xy: expected %0d, actual %0d", e.txy, txy);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow: expected %0d, actual %0d", e.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rot.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_sigma_xx = '0;
  logic signed [31:0] in_sigma_yy = '0;
  logic signed [31:0] in_tau_xy = '0;
  logic signed [15:0] in_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_rot_sigma_xx;
  logic signed [31:0] out_rot_sigma_yy;
  logic signed [31:0] out_rot_tau_xy;
  logic               out_overflow;

  rotation_scoreboard rot_sb = new();
  logic no_idle = 1'b0;
  int stall_left = 0;
  int cycle_cnt = 0;

  plane_stress_rotation i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sigma_xx      (in_sigma_xx),
    .in_sigma_yy      (in_sigma_yy),
    .in_tau_xy        (in_tau_xy),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rot_sigma_xx (out_rot_sigma_xx),
    .out_rot_sigma_yy (out_rot_sigma_yy),
    .out_rot_tau_xy   (out_rot_tau_xy),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic signed [31:0] rand_stress();
    logic signed [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) == 0) return v;
    return v >>> $urandom_range(1, 27);
  endfunction

  task automatic send_stress(input logic signed [31:0] sxx, input logic signed [31:0] syy,
                             input logic signed [31:0] txy, input logic signed [15:0] ang);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sigma_xx <= sxx;
    in_sigma_yy <= syy;
    in_tau_xy <= txy;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
    rot_sb.note_input(sxx, syy, txy, ang);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (rot_sb.pending() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      rot_sb.check_result(out_rot_sigma_xx, out_rot_sigma_yy, out_rot_tau_xy, out_overflow);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] sxx, syy, txy;
    logic signed [15:0] ang;
    int r, a;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_stress(0, 0, 0, 0);
    send_stress(STRESS_MAX, STRESS_MIN, 0, 0);
    send_stress(STRESS_MIN, STRESS_MAX, STRESS_MAX, 0);
    send_stress(1, -1, 1, 25736);
    send_stress(STRESS_MAX, STRESS_MAX, STRESS_MAX, 6434);
    send_stress(STRESS_MIN, STRESS_MIN, STRESS_MIN, 6434);
    send_stress(STRESS_MAX, STRESS_MIN, STRESS_MAX, -6434);
    send_stress(65536, -65536, 32768, 12867);
    send_stress(65536, -65536, 32768, 12868);
    send_stress(65536, -65536, 32768, -12867);
    send_stress(65536, -65536, 32768, -12868);
    send_stress(-196608, 131072, -98304, 25736);
    send_stress(-196608, 131072, -98304, -25736);
    send_stress(-196608, 131072, -98304, 25737);
    send_stress(-196608, 131072, -98304, -25737);
    send_stress(-196608, 131072, -98304, 16'sh7fff);
    send_stress(-196608, 131072, -98304, 16'sh8000);
    send_stress(STRESS_MIN, STRESS_MIN, STRESS_MAX, 16'sh7fff);
    send_stress(123456, -654321, 98765, 1);
    send_stress(STRESS_MAX, 0, STRESS_MIN, -1);
    drain_results();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 3) drain_results();
      no_idle = (n >= 600 && n < 700);
      sxx = rand_stress();
      syy = rand_stress();
      txy = rand_stress();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        a = int'($urandom_range(0, 51472)) - 25736;
        ang = 16'(a);
      end else if (r < 92) begin
        ang = 16'($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0: ang = 0;
          1: ang = 25736;
          2: ang = -25736;
          3: ang = 12868;
          4: ang = -12868;
          default: ang = 6434;
        endcase
      end
      send_stress(sxx, syy, txy, ang);
    end
    no_idle = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (rot_sb.errors == 0 && rot_sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
